@@ sv/csd_pkg.sv @@
`timescale 1ns / 1ps
// Cascade split depth: shared constants, register codes, side-band struct
// and the elaboration-time root table used by the exp2 pipeline.
// No dependencies.
package csd_pkg;

    // Configuration register codes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd3;

    // Field widths
    localparam int DIST_W    = 32;
    localparam int LAMBDA_W  = 17;
    localparam int CNT_W     = 4;
    localparam int DEPTH_W   = 17;
    localparam int LOG_INT_W = 5;
    localparam int MANT_W    = 31;
    localparam int EXP_W     = 32;
    localparam int PROD_W    = 64;
    localparam int BLEND_W   = LAMBDA_W + DIST_W;

    // Parameter defaults
    localparam int DEF_MAX_CASCADES  = 8;
    localparam int DEF_FRACTION_BITS = 16;

    // Small divider: quotient bits per stage; ratio divider: quotient bits total
    localparam int SDIV_STEPS  = 4;
    localparam int RATIO_STEPS = 18;

    // Reset values
    localparam logic [DIST_W-1:0]   NEAR_RST   = 32'd6554;
    localparam logic [DIST_W-1:0]   FAR_RST    = 32'd65536000;
    localparam logic [LAMBDA_W-1:0] BLEND_RST  = 17'd32768;
    localparam logic [CNT_W-1:0]    TOTAL_RST  = 4'd3;
    localparam logic [LAMBDA_W-1:0] LAMBDA_ONE = 17'd65536;
    localparam logic [DEPTH_W-1:0]  DEPTH_ONE  = 17'd65536;

    // Q2.30 constants
    localparam logic [EXP_W-1:0]  Q30_ONE  = 32'h4000_0000;
    localparam logic [PROD_W-1:0] Q30_HALF = 64'h0000_0000_2000_0000;

    // Per-transaction side data carried along the pipeline
    typedef struct packed {
        logic [CNT_W-1:0]     idx;
        logic [DIST_W-1:0]    near;
        logic [DIST_W-1:0]    far;
        logic [CNT_W-1:0]     total;
        logic [LAMBDA_W-1:0]  lambda;
        logic                 bad;
        logic [LOG_INT_W-1:0] pow_int;
        logic [DIST_W-1:0]    lin_split;
    } t_side;

    // Floor integer square root (elaboration only)
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int s = 0; s < 32; s++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(2^-j) in Q2.30, by repeated square roots from sqrt(2)
    function automatic logic [EXP_W-1:0] exp_root(input int j);
        logic [63:0] root;
        root = isqrt64(64'd2 << 60);
        for (int s = 1; s < j; s++) begin
            root = isqrt64(root << 30);
        end
        return root[EXP_W-1:0];
    endfunction

endpackage

@@ sv/cascade_split_depth_core.sv @@
`timescale 1ns / 1ps
// Cascade split depth core: top level, configuration registers, pipeline
// control and the blend/map datapath. Depends on csd_pkg, csd_log2, csd_sdiv, csd_exp2 and csd_ratio.
//
// Usage:
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user
//   writes it only while no transaction is in flight; the block does not enforce it.
//   Input channel i_in_valid/o_in_ready carries a cascade index; output
//   channel o_out_valid/i_out_ready returns the reversed depth and a flag.
//   Throughput: one transaction per cycle while the skid register is empty.
//   From acceptance to o_out_valid a transaction passes the log2 and exp2
//   chains, one bit per stage, the exponent divider and the 18-stage depth
//   divider, with the blend and map registers between them.
//   The whole pipeline advances on one enable. A skid register at the end
//   catches the result when the receiver stalls, so one more transaction
//   is taken in that cycle; while the skid is full o_in_ready is low and
//   the pipeline holds.
//   Reset clears the valid bits and the skid and loads the register
//   defaults; no clearing pass is needed.
module cascade_split_depth_core import csd_pkg::*; #(
    parameter int MAX_CASCADES  = DEF_MAX_CASCADES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIST_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CNT_W-1:0]     i_split_index,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DEPTH_W-1:0]   o_split_depth,
    output logic                 o_bad_setting
);

    localparam int FB      = FRACTION_BITS;
    localparam int LW      = LOG_INT_W + FB;
    localparam int XE_W    = CNT_W + LW + 1;
    localparam int XL_W    = CNT_W + DIST_W + 1;
    localparam int DL_LAT  = (XL_W + SDIV_STEPS - 1) / SDIV_STEPS;
    localparam int DE_LAT  = (XE_W + SDIV_STEPS - 1) / SDIV_STEPS;
    localparam int S_CLIN  = DL_LAT + 1;
    localparam int S_LE    = FB + 2;
    localparam int S_EX0   = S_LE + DE_LAT + 1;
    localparam int S_PR    = S_EX0 + FB;
    localparam int S_CL    = S_PR + 1;
    localparam int S_BM    = S_CL + 1;
    localparam int S_BS    = S_BM + 1;
    localparam int S_ND    = S_BS + 1;
    localparam int S_OUT   = S_ND + RATIO_STEPS + 1;
    localparam int NS      = S_OUT + 1;
    localparam logic [CNT_W:0] MAX_CNT = (CNT_W + 1)'(MAX_CASCADES);

    // Configuration registers
    logic [DIST_W-1:0]   r_near;
    logic [DIST_W-1:0]   r_far;
    logic [LAMBDA_W-1:0] r_blend;
    logic [CNT_W-1:0]    r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near  <= NEAR_RST;
            r_far   <= FAR_RST;
            r_blend <= BLEND_RST;
            r_total <= TOTAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NEAR:  r_near  <= i_cfg_data;
                REG_FAR:   r_far   <= i_cfg_data;
                REG_BLEND: r_blend <= i_cfg_data[LAMBDA_W-1:0];
                REG_TOTAL: r_total <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: one enable, held off only by a full skid
    logic          en;
    logic [NS-1:0] r_vld;
    logic          r_sk_vld;

    assign en         = !r_sk_vld;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_in_valid};
        end
    end

    // Side data
    t_side r_side [NS];
    t_side n_side [NS];

    logic [XL_W-1:0]   cl_q;
    logic [XE_W-1:0]   e_q;

    always_comb begin
        n_side[0].idx       = i_split_index;
        n_side[0].near      = r_near;
        n_side[0].far       = r_far;
        n_side[0].total     = r_total;
        n_side[0].lambda    = (r_blend > LAMBDA_ONE) ? LAMBDA_ONE : r_blend;
        n_side[0].bad       = (r_near == '0) || (r_near >= r_far) || (r_total == '0)
                              || ({1'b0, r_total} > MAX_CNT) || (i_split_index > r_total);
        n_side[0].pow_int   = '0;
        n_side[0].lin_split = '0;
        for (int s = 1; s < NS; s++) begin
            n_side[s] = r_side[s-1];
            if (s == S_CLIN) begin
                n_side[s].lin_split = r_side[s-1].near + cl_q[DIST_W-1:0];
            end
            if (s == S_EX0) begin
                n_side[s].pow_int = e_q[FB+LOG_INT_W-1:FB];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NS; s++) begin
                r_side[s] <= n_side[s];
            end
        end
    end

    // Linear split: i*(f-n) + N/2, divided by N
    logic [XL_W-1:0] r_xl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xl <= XL_W'(i_split_index) * XL_W'(r_far - r_near) + XL_W'(r_total >> 1);
        end
    end

    csd_sdiv #(.XW(XL_W), .STEPS(SDIV_STEPS)) u_lin_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_xl),
        .i_d   (r_side[0].total),
        .o_q   (cl_q)
    );

    // log2 of far and near
    logic [LW-1:0] log_far;
    logic [LW-1:0] log_near;

    csd_log2 #(.FB(FB)) u_log_far (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_side[0].far),
        .o_log (log_far)
    );

    csd_log2 #(.FB(FB)) u_log_near (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_side[0].near),
        .o_log (log_near)
    );

    // Exponent numerator: i*L + N/2
    logic [XE_W-1:0] r_xe;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xe <= XE_W'(r_side[S_LE-1].idx) * XE_W'(log_far - log_near)
                    + XE_W'(r_side[S_LE-1].total >> 1);
        end
    end

    csd_sdiv #(.XW(XE_W), .STEPS(SDIV_STEPS)) u_exp_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_xe),
        .i_d   (r_side[S_LE].total),
        .o_q   (e_q)
    );

    // Fractional power
    logic [EXP_W-1:0] pow_frac;

    csd_exp2 #(.FB(FB)) u_exp (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_frac (e_q[FB-1:0]),
        .o_pow  (pow_frac)
    );

    // Log split: n * pow, scaled by 2^k and capped at far
    logic [PROD_W-1:0]  r_prod;
    logic [DIST_W-1:0]  r_clog;
    logic [PROD_W:0]    clog_wide;
    logic [LOG_INT_W-1:0] k_cl;

    assign k_cl = r_side[S_PR].pow_int;

    always_comb begin
        if (k_cl >= LOG_INT_W'(30)) begin
            clog_wide = {1'b0, r_prod} << (k_cl - LOG_INT_W'(30));
        end else begin
            clog_wide = ({1'b0, r_prod} + ((PROD_W + 1)'(1) << (LOG_INT_W'(29) - k_cl)))
                        >> (LOG_INT_W'(30) - k_cl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= PROD_W'(r_side[S_PR-1].near) * PROD_W'(pow_frac);
            r_clog <= (clog_wide > (PROD_W + 1)'(r_side[S_PR].far)) ?
                      r_side[S_PR].far : clog_wide[DIST_W-1:0];
        end
    end

    // Blend, then clamp to [near, far]
    logic [BLEND_W-1:0] r_pa;
    logic [BLEND_W-1:0] r_pb;
    logic [DIST_W-1:0]  r_c;
    logic [BLEND_W:0]   blend_sum;
    logic [BLEND_W-16:0] c_wide;

    assign blend_sum = (BLEND_W + 1)'(r_pa) + (BLEND_W + 1)'(r_pb) + (BLEND_W + 1)'(32768);
    assign c_wide    = blend_sum[BLEND_W:16];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa <= BLEND_W'(r_side[S_CL].lambda) * BLEND_W'(r_clog);
            r_pb <= BLEND_W'(LAMBDA_ONE - r_side[S_CL].lambda)
                    * BLEND_W'(r_side[S_CL].lin_split);
            if (c_wide < (BLEND_W - 15)'(r_side[S_BM].near)) begin
                r_c <= r_side[S_BM].near;
            end else if (c_wide > (BLEND_W - 15)'(r_side[S_BM].far)) begin
                r_c <= r_side[S_BM].far;
            end else begin
                r_c <= c_wide[DIST_W-1:0];
            end
        end
    end

    // Depth ratio n*(f-c) / ((f-n)*c)
    logic [PROD_W-1:0]      r_num;
    logic [PROD_W-1:0]      r_den;
    logic [RATIO_STEPS-1:0] ratio_q;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num <= PROD_W'(r_side[S_BS].near) * PROD_W'(r_side[S_BS].far - r_c);
            r_den <= PROD_W'(r_side[S_BS].far - r_side[S_BS].near) * PROD_W'(r_c);
        end
    end

    csd_ratio u_ratio (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num),
        .i_den (r_den),
        .o_q   (ratio_q)
    );

    // Output stage: round half up, cap at 1.0, force zero on a bad setting
    logic [RATIO_STEPS-1:0] q_rnd;
    logic [DEPTH_W-1:0]     r_depth;
    logic                   r_bad;

    assign q_rnd = (ratio_q + RATIO_STEPS'(1)) >> 1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad <= r_side[S_OUT-1].bad;
            if (r_side[S_OUT-1].bad) begin
                r_depth <= '0;
            end else if (q_rnd > RATIO_STEPS'(DEPTH_ONE)) begin
                r_depth <= DEPTH_ONE;
            end else begin
                r_depth <= q_rnd[DEPTH_W-1:0];
            end
        end
    end

    // Skid register
    logic [DEPTH_W-1:0] r_sk_depth;
    logic               r_sk_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (i_out_ready) r_sk_vld <= 1'b0;
        end else if (r_vld[NS-1] && !i_out_ready) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_vld) begin
            r_sk_depth <= r_depth;
            r_sk_bad   <= r_bad;
        end
    end

    assign o_out_valid   = r_sk_vld || r_vld[NS-1];
    assign o_split_depth = r_sk_vld ? r_sk_depth : r_depth;
    assign o_bad_setting = r_sk_vld ? r_sk_bad : r_bad;

`ifndef ASSERT_OFF
    // Skid fills only from a stalled last stage
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_vld) |-> $past(r_vld[NS-1] && !i_out_ready))
        else $error("skid filled without a stalled result");

    // A flagged result always carries zero depth
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_setting) |-> (o_split_depth == '0))
        else $error("bad setting with nonzero depth");

    // Depth never above 1.0
    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_split_depth <= DEPTH_ONE))
        else $error("depth above one");

    // While the skid holds a result the pipeline is frozen
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_sk_vld) && r_sk_vld) |-> $stable(r_vld))
        else $error("pipeline moved while skid full");
`endif

endmodule

@@ sv/csd_log2.sv @@
`timescale 1ns / 1ps
// Pipelined fixed-point log2: one normalise stage, then one
// square-and-compare stage per fraction bit. Depends on csd_pkg.
module csd_log2 import csd_pkg::*; #(
    parameter int FB = DEF_FRACTION_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [DIST_W-1:0]       i_x,
    output logic [LOG_INT_W+FB-1:0] o_log
);

    logic [LOG_INT_W-1:0] r_top [FB+1];
    logic [MANT_W-1:0]    r_m   [FB+1];
    logic [FB-1:0]        r_fr  [FB+1];

    logic [LOG_INT_W-1:0] n_top;
    logic [MANT_W-1:0]    m0;
    logic [MANT_W-1:0]    n_m   [FB+1];
    logic [FB-1:0]        n_fr  [FB+1];

    // Leading-one position and Q1.30 mantissa
    always_comb begin
        logic [2*MANT_W-1:0] wide;
        n_top = '0;
        for (int b = 0; b < DIST_W; b++) begin
            if (i_x[b]) n_top = LOG_INT_W'(b);
        end
        wide = {i_x, 30'd0} >> n_top;
        m0   = wide[MANT_W-1:0];
    end

    // One fraction bit per stage
    always_comb begin
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     sh;
        n_m[0]  = m0;
        n_fr[0] = '0;
        for (int s = 1; s <= FB; s++) begin
            sq = r_m[s-1] * r_m[s-1];
            sh = sq[2*MANT_W-1:MANT_W-1];
            if (sh[MANT_W]) begin
                n_m[s]  = sh[MANT_W:1];
                n_fr[s] = {r_fr[s-1][FB-2:0], 1'b1};
            end else begin
                n_m[s]  = sh[MANT_W-1:0];
                n_fr[s] = {r_fr[s-1][FB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top[0] <= n_top;
            for (int s = 0; s <= FB; s++) begin
                r_m[s]  <= n_m[s];
                r_fr[s] <= n_fr[s];
            end
            for (int s = 1; s <= FB; s++) begin
                r_top[s] <= r_top[s-1];
            end
        end
    end

    assign o_log = {r_top[FB], r_fr[FB]};

endmodule

@@ sv/csd_sdiv.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider for a wide dividend over a narrow divisor,
// STEPS quotient bits per stage. Depends on csd_pkg.
module csd_sdiv import csd_pkg::*; #(
    parameter int XW    = 32,
    parameter int STEPS = SDIV_STEPS
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [XW-1:0]    i_x,
    input  logic [CNT_W-1:0] i_d,
    output logic [XW-1:0]    o_q
);

    localparam int LAT = (XW + STEPS - 1) / STEPS;
    localparam int PW  = LAT * STEPS;

    logic [PW-1:0]    r_x [LAT];
    logic [PW-1:0]    r_q [LAT];
    logic [CNT_W-1:0] r_r [LAT];
    logic [CNT_W-1:0] r_d [LAT];

    logic [PW-1:0]    n_x [LAT];
    logic [PW-1:0]    n_q [LAT];
    logic [CNT_W-1:0] n_r [LAT];

    // Shift in dividend bits, compare-subtract against the divisor
    always_comb begin
        logic [PW-1:0]    x;
        logic [PW-1:0]    q;
        logic [CNT_W:0]   r;
        logic [CNT_W-1:0] d;
        for (int s = 0; s < LAT; s++) begin
            if (s == 0) begin
                x = PW'(i_x);
                q = '0;
                r = '0;
                d = i_d;
            end else begin
                x = r_x[s-1];
                q = r_q[s-1];
                r = {1'b0, r_r[s-1]};
                d = r_d[s-1];
            end
            for (int t = 0; t < STEPS; t++) begin
                r = {r[CNT_W-1:0], x[PW-1]};
                x = x << 1;
                if (r >= {1'b0, d}) begin
                    r = r - {1'b0, d};
                    q = {q[PW-2:0], 1'b1};
                end else begin
                    q = {q[PW-2:0], 1'b0};
                end
            end
            n_x[s] = x;
            n_q[s] = q;
            n_r[s] = r[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_d;
            for (int s = 0; s < LAT; s++) begin
                r_x[s] <= n_x[s];
                r_q[s] <= n_q[s];
                r_r[s] <= n_r[s];
            end
            for (int s = 1; s < LAT; s++) begin
                r_d[s] <= r_d[s-1];
            end
        end
    end

    assign o_q = r_q[LAT-1][XW-1:0];

endmodule

@@ sv/csd_exp2.sv @@
`timescale 1ns / 1ps
// Pipelined 2^frac in Q2.30: one conditional multiply by a constant root
// per fraction bit. Depends on csd_pkg (root table function).
module csd_exp2 import csd_pkg::*; #(
    parameter int FB = DEF_FRACTION_BITS
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [FB-1:0]    i_frac,
    output logic [EXP_W-1:0] o_pow
);

    logic [EXP_W-1:0] r_p [FB];
    logic [FB-1:0]    r_e [FB];

    for (genvar j = 0; j < FB; j++) begin : g_stage
        localparam logic [EXP_W-1:0] ROOT = exp_root(j + 1);
        logic [EXP_W-1:0]  p_in;
        logic [FB-1:0]     e_in;
        logic [PROD_W-1:0] prod;
        logic [EXP_W-1:0]  n_p;

        if (j == 0) begin : g_first
            assign p_in = Q30_ONE;
            assign e_in = i_frac;
        end else begin : g_next
            assign p_in = r_p[j-1];
            assign e_in = r_e[j-1];
        end

        // multiply with round half up back to Q2.30
        assign prod = PROD_W'(p_in) * PROD_W'(ROOT) + Q30_HALF;
        assign n_p  = e_in[FB-1-j] ? prod[EXP_W+29:30] : p_in;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[j] <= n_p;
                r_e[j] <= e_in;
            end
        end
    end

    assign o_pow = r_p[FB-1];

endmodule

@@ sv/csd_ratio.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider for num/den with num <= den, one quotient
// bit per stage, giving Q1.17 before rounding. Depends on csd_pkg.
module csd_ratio import csd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [PROD_W-1:0]      i_num,
    input  logic [PROD_W-1:0]      i_den,
    output logic [RATIO_STEPS-1:0] o_q
);

    logic [PROD_W-1:0]      r_r [RATIO_STEPS];
    logic [PROD_W-1:0]      r_d [RATIO_STEPS];
    logic [RATIO_STEPS-1:0] r_q [RATIO_STEPS];

    logic [PROD_W-1:0]      n_r [RATIO_STEPS];
    logic [RATIO_STEPS-1:0] n_q [RATIO_STEPS];

    always_comb begin
        logic [PROD_W:0] sh;
        logic            ge;
        // integer bit
        ge     = i_num >= i_den;
        n_r[0] = ge ? i_num - i_den : i_num;
        n_q[0] = RATIO_STEPS'(ge);
        // fraction bits
        for (int s = 1; s < RATIO_STEPS; s++) begin
            sh = {r_r[s-1], 1'b0};
            ge = sh >= {1'b0, r_d[s-1]};
            if (ge) begin
                sh = sh - {1'b0, r_d[s-1]};
            end
            n_r[s] = sh[PROD_W-1:0];
            n_q[s] = {r_q[s-1][RATIO_STEPS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_den;
            for (int s = 0; s < RATIO_STEPS; s++) begin
                r_r[s] <= n_r[s];
                r_q[s] <= n_q[s];
            end
            for (int s = 1; s < RATIO_STEPS; s++) begin
                r_d[s] <= r_d[s-1];
            end
        end
    end

    assign o_q = r_q[RATIO_STEPS-1];

endmodule

@@ tb/csd_checker.sv @@
`timescale 1ns / 1ps
// Checker for the cascade split depth core: follows register writes, predicts
// the depth of every accepted index and compares it with the returned result.
// Depends on csd_pkg.
module csd_checker import csd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIST_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [CNT_W-1:0]     i_split_index,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [DEPTH_W-1:0]   i_split_depth,
    input  logic                 i_bad_setting,
    output int                   o_fail_count,
    output int                   o_outstanding,
    output int                   o_checked,
    output int                   o_flagged
);

    localparam int FB      = DEF_FRACTION_BITS;
    localparam int MAX_CAS = DEF_MAX_CASCADES;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               bad;
    } t_depth_result;

    // Shadow copy of the configuration registers
    logic [DIST_W-1:0]   near_q;
    logic [DIST_W-1:0]   far_q;
    logic [LAMBDA_W-1:0] lambda_q;
    logic [CNT_W-1:0]    total_q;

    t_depth_result expected_depths[$];
    logic [63:0]   root_tab[1:FB];

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 with FB fraction bits, by repeated squaring of a Q1.30 mantissa
    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        int          top;
        logic [63:0] m;
        logic [63:0] frac;
        top  = 0;
        frac = '0;
        while (top < 63 && (x >> (top + 1)) != 0) top++;
        if (top > 30) m = x >> (top - 30);
        else m = x << (30 - top);
        for (int j = 0; j < FB; j++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(top) << FB) | frac;
    endfunction

    // 2^(fraction of e) in Q2.30
    function automatic logic [63:0] pow2_frac(input logic [63:0] e);
        logic [63:0] p;
        p = 64'd1 << 30;
        for (int j = 1; j <= FB; j++) begin
            if (e[FB-j]) p = (p * root_tab[j] + (64'd1 << 29)) >> 30;
        end
        return p;
    endfunction

    // num/den in Q1.16, rounded half up, capped at one
    function automatic logic [63:0] ratio_q16(input logic [63:0] num,
                                              input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        logic        carry;
        q = '0;
        r = num;
        if (r >= den) begin
            q = 64'd1;
            r = r - den;
        end
        for (int j = 0; j < 17; j++) begin
            carry = r[63];
            r = r << 1;
            q = q << 1;
            if (carry || r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        q = (q + 1) >> 1;
        return (q > 64'd65536) ? 64'd65536 : q;
    endfunction

    function automatic t_depth_result predict_split(input logic [CNT_W-1:0] idx);
        t_depth_result res;
        logic [63:0]   i, n, f, tot, lam, span, l2, e, k, pw, prod;
        logic [63:0]   c_log, c_lin, c, s;
        i   = 64'(idx);
        n   = 64'(near_q);
        f   = 64'(far_q);
        tot = 64'(total_q);
        lam = (lambda_q > LAMBDA_ONE) ? 64'd65536 : 64'(lambda_q);
        res = '0;
        if (n == 0 || n >= f || tot == 0 || tot > MAX_CAS || i > tot) begin
            res.bad = 1'b1;
            return res;
        end
        span = f - n;
        l2   = log2_fixed(f) - log2_fixed(n);
        e    = (i * l2 + tot / 2) / tot;
        k    = e >> FB;
        pw   = pow2_frac(e);
        prod = n * pw;
        if (k >= 30) begin
            s = k - 30;
            if (s >= 32 || (prod >> (62 - ((s > 62) ? 62 : s))) != 0) c_log = f;
            else c_log = prod << s;
        end else begin
            c_log = (prod + (64'd1 << (29 - k))) >> (30 - k);
        end
        if (c_log > f) c_log = f;
        c_lin = n + (i * span + tot / 2) / tot;
        c = (lam * c_log + (64'd65536 - lam) * c_lin + 64'd32768) >> 16;
        if (c < n) c = n;
        if (c > f) c = f;
        res.depth = DEPTH_W'(ratio_q16(n * (f - c), span * c));
        return res;
    endfunction

    initial begin
        root_tab[1] = sqrt_floor(64'd2 << 60);
        for (int j = 2; j <= FB; j++) root_tab[j] = sqrt_floor(root_tab[j-1] << 30);
    end

    assign o_outstanding = expected_depths.size();

    // Register shadow, prediction on input transactions, compare on output
    always @(posedge i_clk) begin
        t_depth_result want;
        if (!i_rst_n) begin
            near_q       <= NEAR_RST;
            far_q        <= FAR_RST;
            lambda_q     <= BLEND_RST;
            total_q      <= TOTAL_RST;
            o_fail_count <= 0;
            o_checked    <= 0;
            o_flagged    <= 0;
            expected_depths.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NEAR:  near_q   <= i_cfg_data;
                    REG_FAR:   far_q    <= i_cfg_data;
                    REG_BLEND: lambda_q <= i_cfg_data[LAMBDA_W-1:0];
                    REG_TOTAL: total_q  <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) expected_depths.push_back(predict_split(i_split_index));
            if (i_out_valid && i_out_ready) begin
                if (expected_depths.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result depth=%0d bad=%0d", $time,
                                 i_split_depth, i_bad_setting);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_depths.pop_front();
                    o_checked <= o_checked + 1;
                    if (want.bad) o_flagged <= o_flagged + 1;
                    if (want.depth !== i_split_depth || want.bad !== i_bad_setting) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch depth exp %0d got %0d, bad exp %0d got %0d",
                                     $time, want.depth, i_split_depth, want.bad, i_bad_setting);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the cascade split depth bench: clock, reset, register settings,
// index stimulus and output back-pressure; verdict from the checker count.
// Depends on csd_pkg, cascade_split_depth_core and csd_checker.
module testbench;
    import csd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 90;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_NEAR;
    logic [DIST_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [CNT_W-1:0]     i_split_index = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [DEPTH_W-1:0]   o_split_depth;
    logic                 o_bad_setting;

    int fail_count, outstanding, checked, flagged;
    int cycles = 0;
    int sent = 0;
    int phases = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;
    bit hold_req = 1'b0;

    cascade_split_depth_core dut (.*);

    csd_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_split_index,
        .i_out_valid(o_out_valid), .i_out_ready, .i_split_depth(o_split_depth),
        .i_bad_setting(o_bad_setting), .o_fail_count(fail_count),
        .o_outstanding(outstanding), .o_checked(checked), .o_flagged(flagged)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        int hold;
        if (hold_req) begin
            hold = 400;
            while (hold > 0) begin
                i_out_ready <= 1'b0;
                @(posedge i_clk);
                hold--;
            end
        end
        i_out_ready <= recv_steady || ($urandom_range(99) >= 32);
    end

    // Write enable is left high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Settings change only once the pipeline is empty
    task automatic load_setting(input logic [31:0] near, input logic [31:0] far,
                                input logic [31:0] lambda, input logic [31:0] total);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        write_reg(REG_NEAR, near);
        write_reg(REG_FAR, far);
        write_reg(REG_BLEND, lambda);
        write_reg(REG_TOTAL, total);
        i_cfg_we <= 1'b0;
        phases++;
    endtask

    // One input transaction; valid stays up until taken
    task automatic send_index(input logic [CNT_W-1:0] idx);
        while (!send_steady && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_split_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_burst(input int count, input int total);
        for (int j = 0; j < count; j++) begin
            if ($urandom_range(9) == 0) send_index(CNT_W'($urandom_range(15)));
            else send_index(CNT_W'($urandom_range(total > 15 ? 15 : total)));
        end
    endtask

    // Mostly well-formed random settings, with invalid ones now and then
    task automatic random_setting(output int total);
        logic [31:0] near, far, lambda;
        case ($urandom_range(5))
            0: begin near = $urandom_range(65536, 1); far = $urandom(); end
            1: begin near = $urandom_range(1 << 20, 1); far = near + $urandom_range(1 << 24, 1); end
            2: begin near = $urandom(); far = $urandom(); end
            3: begin near = 32'd1; far = 32'hFFFF_FFFF - $urandom_range(1000); end
            default: begin near = $urandom_range(1 << 16, 1 << 12); far = near << $urandom_range(12, 1); end
        endcase
        if (near == 0 && $urandom_range(3) != 0) near = 1;
        if (near >= far && $urandom_range(3) != 0) begin
            near = (far > 2) ? far / 2 : 1;
            if (far <= near) far = near + 1;
        end
        lambda = ($urandom_range(5) == 0) ? $urandom() : $urandom_range(65536);
        total  = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
        load_setting(near, far, lambda, total | ($urandom() & 32'hFFFF_FFF0));
    endtask

    initial begin
        int total;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: indices 0 to 8 and 15 under the defaults
        for (int j = 0; j <= 8; j++) send_index(CNT_W'(j));
        send_index(4'hF);
        // Extremes of the registers and the invalid settings
        load_setting(32'd1, 32'hFFFF_FFFF, 32'd0, 32'd8);
        send_index(4'd0); send_index(4'd4); send_index(4'd8); send_index(4'd9);
        load_setting(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd65536, 32'd1);
        send_index(4'd0); send_index(4'd1);
        load_setting(32'd65536, 32'd655360, 32'h0001_FFFF, 32'd7);
        send_index(4'd3); send_index(4'd7);
        load_setting(32'd0, 32'd1000, 32'd32768, 32'd3);
        send_index(4'd1);
        load_setting(32'd5000, 32'd5000, 32'd32768, 32'd3);
        send_index(4'd2);
        load_setting(32'd9000, 32'd5000, 32'd32768, 32'd3);
        send_index(4'd2);
        load_setting(32'd100, 32'd100000, 32'd32768, 32'd0);
        send_index(4'd0);
        load_setting(32'd100, 32'd100000, 32'd32768, 32'hFFFF_FFF9);
        send_index(4'd1);
        load_setting(32'd100, 32'd100000, 32'd32768, 32'd15);
        send_index(4'd15);

        // Pressure: receiver holds off while indices keep coming
        load_setting(32'd6554, 32'd65536000, 32'd40000, 32'd8);
        send_steady = 1'b1;
        hold_req    = 1'b1;
        repeat (2) @(posedge i_clk);
        hold_req    = 1'b0;
        send_burst(120, 8);
        recv_steady = 1'b1;
        send_burst(60, 8);
        send_steady = 1'b0;
        recv_steady = 1'b0;

        // Random phases
        while (sent < 950) begin
            random_setting(total);
            send_burst($urandom_range(90, 40), total);
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        wait (outstanding == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("sent %0d indices over %0d register settings", sent, phases);
        $display("checked %0d results, %0d with the invalid-setting flag", checked, flagged);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
